/* sv/ftp_rp_pkg.sv */
// Package for the FTP reply parser: parse phases, character codes, status codes
// and the result record. No dependencies.
package ftp_rp_pkg;

    typedef enum logic [2:0] {
        PH_CODE  = 3'd0,
        PH_MULTI = 3'd1,
        PH_SKIP  = 3'd2,
        PH_PORT  = 3'd3,
        PH_TAIL  = 3'd4
    } t_phase;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_CODE  = 2'd1;
    localparam logic [1:0] ST_LONG_PORT = 2'd2;

    localparam logic [2:0] CODE_LEN   = 3'd3;
    localparam logic [2:0] CNT_MAX    = 3'd7;
    localparam logic [2:0] LM_NOMATCH = 3'd4;
    localparam logic [2:0] COMMA_SKIP = 3'd4;

    typedef struct packed {
        logic [9:0]  reply_code;
        logic [15:0] data_port;
        logic [1:0]  status;
    } t_result;

endpackage

/* sv/ftp_rp_core.sv */
// Parse state and next-state logic for one reply character per enabled cycle.
// Depends on ftp_rp_pkg.
module ftp_rp_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [7:0]            i_byte,
    input  logic                  i_pasv_mode,
    output logic                  o_emit,
    output ftp_rp_pkg::t_result   o_result
);

    ftp_rp_pkg::t_phase r_phase, n_phase;
    logic [9:0]  r_code, n_code;
    logic [3:0]  r_dig [0:2];
    logic [3:0]  n_dig [0:2];
    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_lmc, n_lmc;
    logic [2:0]  r_commas, n_commas;
    logic [9:0]  r_num, n_num;
    logic [15:0] r_port, n_port;
    logic [1:0]  r_err, n_err;

    logic        digit;
    logic [3:0]  dval;
    logic [3:0]  exp_dig;
    logic        emit;
    logic [15:0] port_out;

    assign digit = (i_byte >= ftp_rp_pkg::CH_ZERO) && (i_byte <= ftp_rp_pkg::CH_NINE);
    assign dval  = digit ? i_byte[3:0] : 4'd0;

    always_comb begin
        case (r_lmc[1:0])
            2'd0:    exp_dig = r_dig[0];
            2'd1:    exp_dig = r_dig[1];
            default: exp_dig = r_dig[2];
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_code   = r_code;
        n_dig    = r_dig;
        n_cnt    = r_cnt;
        n_lmc    = r_lmc;
        n_commas = r_commas;
        n_num    = r_num;
        n_port   = r_port;
        n_err    = r_err;
        emit     = 1'b0;
        port_out = r_port;

        case (r_phase)
            ftp_rp_pkg::PH_MULTI: begin
                if (i_byte == ftp_rp_pkg::CH_LF) begin
                    n_lmc = 3'd0;
                end else if (r_lmc < ftp_rp_pkg::CODE_LEN) begin
                    if (digit && dval == exp_dig) begin
                        n_lmc = r_lmc + 3'd1;
                    end else begin
                        n_lmc = ftp_rp_pkg::LM_NOMATCH;
                    end
                end else if (r_lmc == ftp_rp_pkg::CODE_LEN) begin
                    if (i_byte == ftp_rp_pkg::CH_SPACE) begin
                        if (i_pasv_mode) begin
                            n_phase  = ftp_rp_pkg::PH_SKIP;
                            n_commas = 3'd0;
                        end else begin
                            n_phase = ftp_rp_pkg::PH_TAIL;
                        end
                    end else begin
                        n_lmc = ftp_rp_pkg::LM_NOMATCH;
                    end
                end
            end
            ftp_rp_pkg::PH_SKIP: begin
                if (i_byte == ftp_rp_pkg::CH_LF) begin
                    emit     = 1'b1;
                    port_out = 16'd0;
                end else if (i_byte == ftp_rp_pkg::CH_COMMA) begin
                    n_commas = r_commas + 3'd1;
                    if (n_commas >= ftp_rp_pkg::COMMA_SKIP) begin
                        n_phase = ftp_rp_pkg::PH_PORT;
                        n_cnt   = 3'd0;
                        n_num   = 10'd0;
                    end
                end
            end
            ftp_rp_pkg::PH_PORT: begin
                if (digit) begin
                    if (r_cnt < ftp_rp_pkg::CODE_LEN) begin
                        n_num = 10'((14'(r_num) * 14'd10) + 14'(dval));
                        n_cnt = r_cnt + 3'd1;
                    end else if (r_err == ftp_rp_pkg::ST_OK) begin
                        n_err = ftp_rp_pkg::ST_LONG_PORT;
                    end
                end else if (i_byte == ftp_rp_pkg::CH_COMMA) begin
                    n_port = r_port + {r_num[7:0], 8'd0};
                    n_num  = 10'd0;
                    n_cnt  = 3'd0;
                end else if (i_byte == ftp_rp_pkg::CH_RPAREN) begin
                    n_port  = r_port + 16'(r_num);
                    n_num   = 10'd0;
                    n_phase = ftp_rp_pkg::PH_TAIL;
                end else if (i_byte == ftp_rp_pkg::CH_LF) begin
                    emit     = 1'b1;
                    port_out = r_port + 16'(r_num);
                end
            end
            ftp_rp_pkg::PH_TAIL: begin
                if (i_byte == ftp_rp_pkg::CH_LF) begin
                    emit = 1'b1;
                end
            end
            default: begin
                n_phase = ftp_rp_pkg::PH_CODE;
                if (i_byte == ftp_rp_pkg::CH_SPACE || i_byte == ftp_rp_pkg::CH_HYPHEN) begin
                    if (r_cnt != ftp_rp_pkg::CODE_LEN) begin
                        n_err = ftp_rp_pkg::ST_BAD_CODE;
                    end
                    if (i_byte == ftp_rp_pkg::CH_HYPHEN) begin
                        n_phase = ftp_rp_pkg::PH_MULTI;
                        n_lmc   = 3'd0;
                    end else if (i_pasv_mode) begin
                        n_phase  = ftp_rp_pkg::PH_SKIP;
                        n_commas = 3'd0;
                    end else begin
                        n_phase = ftp_rp_pkg::PH_TAIL;
                    end
                end else begin
                    if (!digit) begin
                        n_err = ftp_rp_pkg::ST_BAD_CODE;
                    end else if (r_cnt < ftp_rp_pkg::CODE_LEN) begin
                        n_code   = 10'((14'(r_code) * 14'd10) + 14'(dval));
                        n_dig[0] = r_dig[1];
                        n_dig[1] = r_dig[2];
                        n_dig[2] = dval;
                    end
                    if (r_cnt < ftp_rp_pkg::CNT_MAX) begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
        endcase

        if (emit) begin
            n_phase  = ftp_rp_pkg::PH_CODE;
            n_code   = 10'd0;
            n_dig[0] = 4'd0;
            n_dig[1] = 4'd0;
            n_dig[2] = 4'd0;
            n_cnt    = 3'd0;
            n_lmc    = 3'd0;
            n_commas = 3'd0;
            n_num    = 10'd0;
            n_port   = 16'd0;
            n_err    = ftp_rp_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ftp_rp_pkg::PH_CODE;
            r_code   <= 10'd0;
            r_dig[0] <= 4'd0;
            r_dig[1] <= 4'd0;
            r_dig[2] <= 4'd0;
            r_cnt    <= 3'd0;
            r_lmc    <= 3'd0;
            r_commas <= 3'd0;
            r_num    <= 10'd0;
            r_port   <= 16'd0;
            r_err    <= ftp_rp_pkg::ST_OK;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_code   <= n_code;
            r_dig    <= n_dig;
            r_cnt    <= n_cnt;
            r_lmc    <= n_lmc;
            r_commas <= n_commas;
            r_num    <= n_num;
            r_port   <= n_port;
            r_err    <= n_err;
        end
    end

    assign o_emit              = i_en && emit;
    assign o_result.reply_code = r_code;
    assign o_result.data_port  = port_out;
    assign o_result.status     = r_err;

endmodule

/* sv/ftp_reply_parser.sv */
// Top level of the FTP reply parser: input byte register, parse core, result register.
// Depends on ftp_rp_pkg and ftp_rp_core.
//
// Takes one reply character per transaction, up to one per clock cycle. A byte is
// registered on acceptance and parsed once the result register is free or being
// taken; a result (reply code, passive data port, status) enters the output register
// as the final line's line feed is parsed. The output register frees in the same cycle
// it is taken, so the input keeps its full rate unless the result side stalls.
// pasv_mode is taken when the final line's code separator is parsed; write it only
// while the block is idle.
module ftp_reply_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_pasv_mode,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [9:0]  o_reply_code,
    output logic [15:0] o_data_port,
    output logic [1:0]  o_status
);

    logic                r_pasv;
    logic                r_in_vld;
    logic [7:0]          r_in_byte;
    logic                r_out_vld;
    ftp_rp_pkg::t_result r_out;

    logic                proc;
    logic                emit;
    ftp_rp_pkg::t_result result;

    assign proc        = r_in_vld && (!r_out_vld || i_res_ready);
    assign o_rx_ready  = !r_in_vld || proc;
    assign o_cfg_ready = 1'b1;

    ftp_rp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (proc),
        .i_byte      (r_in_byte),
        .i_pasv_mode (r_pasv),
        .o_emit      (emit),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pasv    <= 1'b0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_pasv <= i_cfg_pasv_mode;
            end
            if (o_rx_ready) begin
                r_in_vld <= i_rx_valid;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_res_valid  = r_out_vld;
    assign o_reply_code = r_out.reply_code;
    assign o_data_port  = r_out.data_port;
    assign o_status     = r_out.status;

endmodule
